>>> rtl/core/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the Caesar/Base64 stream decoder
// Payload structs for both channels, the group entry that crosses the queue,
// register map and sextet helpers.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Input word: one obfuscated character
  typedef struct packed {
    logic [7:0] sym;
    logic       sym_last;
  } sym_item_t;

  // Output word: one decoded byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_last;
  } byte_item_t;

  // One decoded group waiting for the byte serializer
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  cnt;   // bytes to send, 1..3
    logic        last;  // group closes the string
  } group_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Configuration port
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SHIFT = 3'h0;
  localparam logic [4:0]  SHIFT_RESET    = 5'd3;

  // Alphabet sizes
  localparam logic [5:0]  LETTER_COUNT   = 6'd26;
  localparam logic [4:0]  DIGIT_COUNT    = 5'd10;

  // Sextet encoding: bit 6 marks padding, bits 5..0 hold the value
  localparam logic [6:0]  PAD_SEXTET     = 7'h40;
  localparam logic [5:0]  DIGIT_BASE     = 6'd52;
  localparam logic [5:0]  LOWER_BASE     = 6'd26;
  localparam logic [5:0]  PLUS_VALUE     = 6'd62;
  localparam logic [5:0]  SLASH_VALUE    = 6'd63;

  // Byte positions inside a group
  localparam logic [1:0]  BYTE_HI        = 2'd0;
  localparam logic [1:0]  BYTE_MID       = 2'd1;
  localparam logic [1:0]  BYTE_LO        = 2'd2;

  // Value bits of a sextet; padding gives zero
  function automatic logic [5:0] sextet_bits(input logic [6:0] sx);
    sextet_bits = sx[6] ? 6'd0 : sx[5:0];
  endfunction

endpackage

>>> rtl/core/caesar_base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caesar_base64_stream_decoder_unit: Caesar-unshift plus Base64 decoder
// Order: the group closed by a character is written into the queue; its bytes
//   then pass through the output register one per cycle while out_stall is low.
// Throughput: one character per cycle in while the queue is not full, one byte
//   per cycle out while out_stall is low, set by the serializer's output register.
// Reset: group position and queue cleared, caesar_shift set to 3; no
//   clearing pass, the sextet store is written before it is read.
// ----------------------------------------------------------------------------
module caesar_base64_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Character input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cbd_pkg::sym_item_t                in_data,
  // Byte output
  output logic                              out_valid,
  input  logic                              out_stall,
  output cbd_pkg::byte_item_t               out_data,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cbd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cbd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import cbd_pkg::*;

  logic [4:0] shift_r, shift_nxt;
  logic       push, pop;
  group_t     push_data, head;
  q_status_t  q_stat;

  // Configuration register
  assign pready = 1'b1;
  always_comb begin
    shift_nxt = shift_r;
    if (psel && penable && pwrite && (paddr == CFG_ADDR_SHIFT)) begin
      shift_nxt = pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
    end else begin
      shift_r <= shift_nxt;
    end
  end

  assign prdata = (paddr == CFG_ADDR_SHIFT) ? {{(CFG_DATA_W - 5){1'b0}}, shift_r} : '0;

  // Classify and assemble groups
  cbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .caesar_shift (shift_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // Decouple front and back
  cbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Serialize bytes
  cbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/cbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_front: character classifier and group assembler
// Removes the Caesar shift, maps the character to a Base64 sextet and
// collects sextets into groups; a finished group is pushed to the queue.
// ----------------------------------------------------------------------------
module cbd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [4:0]            caesar_shift,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cbd_pkg::sym_item_t    in_data,
  input  cbd_pkg::q_status_t    q_stat,
  output logic                  push,
  output cbd_pkg::group_t       push_data
);
  import cbd_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [6:0] store_r [0:2];

  logic       accept;
  logic       complete;
  logic [7:0] c;
  logic       is_upper, is_lower, is_digit;
  logic [4:0] s26;
  logic [3:0] s10;
  logic [7:0] upper_off, lower_off, digit_off;
  logic [4:0] letter;
  logic [5:0] letter_un;
  logic [3:0] digit;
  logic [4:0] digit_un;
  logic [6:0] sx;
  logic [6:0] c1, c2, c3, c4;

  // Stall only on a full queue
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign c        = in_data.sym;

  // Reduce the shift for letters and digits
  always_comb begin
    s26 = (caesar_shift >= LETTER_COUNT[4:0]) ? caesar_shift - LETTER_COUNT[4:0]
                                              : caesar_shift;
    priority if (caesar_shift >= 5'd30) begin
      s10 = 4'(caesar_shift - 5'd30);
    end else if (caesar_shift >= 5'd20) begin
      s10 = 4'(caesar_shift - 5'd20);
    end else if (caesar_shift >= DIGIT_COUNT) begin
      s10 = 4'(caesar_shift - DIGIT_COUNT);
    end else begin
      s10 = caesar_shift[3:0];
    end
  end

  // Classify and unshift the character
  always_comb begin
    is_upper  = (c >= 8'h41) && (c <= 8'h5A);
    is_lower  = (c >= 8'h61) && (c <= 8'h7A);
    is_digit  = (c >= 8'h30) && (c <= 8'h39);
    upper_off = c - 8'h41;
    lower_off = c - 8'h61;
    digit_off = c - 8'h30;
    letter    = is_upper ? upper_off[4:0] : lower_off[4:0];
    letter_un = (letter >= s26) ? {1'b0, letter} - {1'b0, s26}
                                : {1'b0, letter} + (LETTER_COUNT - {1'b0, s26});
    digit     = digit_off[3:0];
    digit_un  = (digit >= s10) ? {1'b0, digit} - {1'b0, s10}
                               : {1'b0, digit} + (DIGIT_COUNT - {1'b0, s10});
    priority if (is_upper) begin
      sx = {1'b0, letter_un};
    end else if (is_lower) begin
      sx = {1'b0, letter_un + LOWER_BASE};
    end else if (is_digit) begin
      sx = {1'b0, {1'b0, digit_un} + DIGIT_BASE};
    end else if (c == 8'h2B) begin
      sx = {1'b0, PLUS_VALUE};
    end else if (c == 8'h2F) begin
      sx = {1'b0, SLASH_VALUE};
    end else begin
      sx = PAD_SEXTET;
    end
  end

  // Assemble the group from the store and the current sextet
  always_comb begin
    c1 = PAD_SEXTET;
    c2 = PAD_SEXTET;
    c3 = PAD_SEXTET;
    c4 = PAD_SEXTET;
    unique case (pos_r)
      2'd0: begin
        c1 = sx;
      end
      2'd1: begin
        c1 = store_r[0];
        c2 = sx;
      end
      2'd2: begin
        c1 = store_r[0];
        c2 = store_r[1];
        c3 = sx;
      end
      default: begin
        c1 = store_r[0];
        c2 = store_r[1];
        c3 = store_r[2];
        c4 = sx;
      end
    endcase
    push_data.word = {sextet_bits(c1), sextet_bits(c2), sextet_bits(c3), sextet_bits(c4)};
    priority if (c3[6] && c4[6]) begin
      push_data.cnt = 2'd1;
    end else if (c4[6]) begin
      push_data.cnt = 2'd2;
    end else begin
      push_data.cnt = 2'd3;
    end
    push_data.last = in_data.sym_last;
  end

  // Close the group on the fourth sextet or the end mark
  assign complete = (pos_r == 2'd3) || in_data.sym_last;
  assign push     = accept && complete;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = complete ? 2'd0 : pos_r + 2'd1;
    end
  end

  // Advance the group position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Hold sextets of the open group
  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      store_r[pos_r] <= sx;
    end
  end

  a_last_closes_group : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.sym_last) |=> (pos_r == 2'd0))
    else $error("group position not cleared after end mark");

endmodule

>>> rtl/core/cbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_queue: group queue between assembler and serializer
// Small circular buffer of decoded groups so front and back stall apart.
// ----------------------------------------------------------------------------
module cbd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cbd_pkg::group_t    push_data,
  input  logic               pop,
  output cbd_pkg::group_t    head,
  output cbd_pkg::q_status_t q_stat
);
  import cbd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  group_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("group pushed into a full queue");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("group popped from an empty queue");

endmodule

>>> rtl/core/cbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_back: byte serializer
// Sends the bytes of the queue head one per cycle through an output register
// while the output is not stalled, and pops the group as its last byte is loaded.
// ----------------------------------------------------------------------------
module cbd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cbd_pkg::group_t      head,
  input  cbd_pkg::q_status_t   q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbd_pkg::byte_item_t  out_data
);
  import cbd_pkg::*;

  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  byte_item_t out_data_r, out_data_nxt;
  logic       load;
  logic       final_byte;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign load       = !out_valid_r || !out_stall;
  assign final_byte = (k_r == head.cnt - 2'd1);
  assign pop        = load && !q_stat.empty && final_byte;

  // Select the next byte and step through the group
  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        unique case (k_r)
          BYTE_HI:  out_data_nxt.data_byte = head.word[23:16];
          BYTE_MID: out_data_nxt.data_byte = head.word[15:8];
          default:  out_data_nxt.data_byte = head.word[7:0];
        endcase
        out_data_nxt.byte_last = head.last && final_byte;
        k_nxt = final_byte ? BYTE_HI : k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= BYTE_HI;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_byte_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != 2'd3) && (q_stat.empty || (k_r < head.cnt)))
    else $error("byte index beyond group size");

endmodule
